@@ src/mcke_pkg.sv @@
// Package for the Morse code keyer encoder: widths, ASCII codes, phase codes,
// the configuration struct and the international Morse element table.
// No dependencies.
package mcke_pkg;

    localparam int unsigned DUR_W  = 16;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned PAT_W  = 5;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned CODE_W = 6;

    // Register indexes on the configuration channel.
    localparam logic [IDX_W-1:0] REG_DOT         = 8'd0;
    localparam logic [IDX_W-1:0] REG_DASH        = 8'd1;
    localparam logic [IDX_W-1:0] REG_ELEMENT_GAP = 8'd2;
    localparam logic [IDX_W-1:0] REG_LETTER_GAP  = 8'd3;
    localparam logic [IDX_W-1:0] REG_WORD_GAP    = 8'd4;

    // Register values after reset.
    localparam logic [DUR_W-1:0] RST_DOT         = 16'd200;
    localparam logic [DUR_W-1:0] RST_DASH        = 16'd600;
    localparam logic [DUR_W-1:0] RST_ELEMENT_GAP = 16'd200;
    localparam logic [DUR_W-1:0] RST_LETTER_GAP  = 16'd600;
    localparam logic [DUR_W-1:0] RST_WORD_GAP    = 16'd1400;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

    localparam logic [CODE_W-1:0] LETTER_COUNT = 6'd26;

    // Sequencer phases.
    localparam logic [1:0] PH_ELEM  = 2'd0;
    localparam logic [1:0] PH_EGAP  = 2'd1;
    localparam logic [1:0] PH_LGAP  = 2'd2;
    localparam logic [1:0] PH_SPACE = 2'd3;

    typedef struct packed {
        logic [DUR_W-1:0] dot_ms;
        logic [DUR_W-1:0] dash_ms;
        logic [DUR_W-1:0] element_gap_ms;
        logic [DUR_W-1:0] letter_gap_ms;
        logic [DUR_W-1:0] word_gap_ms;
    } t_cfg;

    // One Morse character: element count and elements, first element in
    // bit 0, a dash coded as 1.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } t_code;

    // Codes 0 to 25 are A to Z, codes 26 to 35 are the digits 0 to 9.
    function automatic t_code lookup_code(input logic [CODE_W-1:0] code);
        t_code c;
        unique case (code)
            6'd0:  c = '{len: 3'd2, pat: 5'b00010};
            6'd1:  c = '{len: 3'd4, pat: 5'b00001};
            6'd2:  c = '{len: 3'd4, pat: 5'b00101};
            6'd3:  c = '{len: 3'd3, pat: 5'b00001};
            6'd4:  c = '{len: 3'd1, pat: 5'b00000};
            6'd5:  c = '{len: 3'd4, pat: 5'b00100};
            6'd6:  c = '{len: 3'd3, pat: 5'b00011};
            6'd7:  c = '{len: 3'd4, pat: 5'b00000};
            6'd8:  c = '{len: 3'd2, pat: 5'b00000};
            6'd9:  c = '{len: 3'd4, pat: 5'b01110};
            6'd10: c = '{len: 3'd3, pat: 5'b00101};
            6'd11: c = '{len: 3'd4, pat: 5'b00010};
            6'd12: c = '{len: 3'd2, pat: 5'b00011};
            6'd13: c = '{len: 3'd2, pat: 5'b00001};
            6'd14: c = '{len: 3'd3, pat: 5'b00111};
            6'd15: c = '{len: 3'd4, pat: 5'b00110};
            6'd16: c = '{len: 3'd4, pat: 5'b01011};
            6'd17: c = '{len: 3'd3, pat: 5'b00010};
            6'd18: c = '{len: 3'd3, pat: 5'b00000};
            6'd19: c = '{len: 3'd1, pat: 5'b00001};
            6'd20: c = '{len: 3'd3, pat: 5'b00100};
            6'd21: c = '{len: 3'd4, pat: 5'b01000};
            6'd22: c = '{len: 3'd3, pat: 5'b00110};
            6'd23: c = '{len: 3'd4, pat: 5'b01001};
            6'd24: c = '{len: 3'd4, pat: 5'b01101};
            6'd25: c = '{len: 3'd4, pat: 5'b00011};
            6'd26: c = '{len: 3'd5, pat: 5'b11111};
            6'd27: c = '{len: 3'd5, pat: 5'b11110};
            6'd28: c = '{len: 3'd5, pat: 5'b11100};
            6'd29: c = '{len: 3'd5, pat: 5'b11000};
            6'd30: c = '{len: 3'd5, pat: 5'b10000};
            6'd31: c = '{len: 3'd5, pat: 5'b00000};
            6'd32: c = '{len: 3'd5, pat: 5'b00001};
            6'd33: c = '{len: 3'd5, pat: 5'b00011};
            6'd34: c = '{len: 3'd5, pat: 5'b00111};
            6'd35: c = '{len: 3'd5, pat: 5'b01111};
            default: c = '{len: 3'd1, pat: 5'b00000};
        endcase
        return c;
    endfunction

endpackage

@@ src/mcke_if.sv @@
// Valid/ready channel interfaces of the Morse code keyer encoder: the
// character channel, the key segment channel and the configuration channel.
// Depends on mcke_pkg.
interface mcke_char_if import mcke_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface mcke_seg_if import mcke_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             key_on;
    logic [DUR_W-1:0] duration_ms;
    logic             last_segment;

    modport source (output valid, output key_on, output duration_ms,
                    output last_segment, input ready);
    modport sink   (input valid, input key_on, input duration_ms,
                    input last_segment, output ready);
endinterface

interface mcke_cfg_if import mcke_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [DUR_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/mcke_segen.sv @@
// Segment sequencer: decodes one character and shifts its Morse elements out
// one key segment per unstalled cycle into a registered output stage.
// Depends on mcke_pkg and mcke_if.
module mcke_segen import mcke_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    mcke_char_if.sink        i_char,
    mcke_seg_if.source       o_seg
);

    logic             r_busy, n_busy;
    logic [1:0]       r_phase, n_phase;
    logic [PAT_W-1:0] r_pat, n_pat;
    logic [LEN_W-1:0] r_cnt, n_cnt;

    logic             r_ovalid, n_ovalid;
    logic             r_key_on, n_key_on;
    logic [DUR_W-1:0] r_dur, n_dur;
    logic             r_last, n_last;

    logic              accept;
    logic              slot_free;
    logic [CHAR_W-1:0] ch_up;
    logic [CHAR_W-1:0] ch_off;
    logic [CODE_W-1:0] code;
    logic              is_letter, is_digit, is_space;
    t_code             lut;
    logic [DUR_W:0]    space_diff;
    logic [DUR_W-1:0]  space_dur;

    assign i_char.ready = !r_busy;
    assign accept       = i_char.valid && !r_busy;
    assign slot_free    = !r_ovalid || o_seg.ready;

    always_comb begin
        if (i_char.char_byte >= CH_LOWER_A && i_char.char_byte <= CH_LOWER_Z) begin
            ch_up = i_char.char_byte - CASE_DIFF;
        end else begin
            ch_up = i_char.char_byte;
        end
        is_letter = (ch_up >= CH_UPPER_A) && (ch_up <= CH_UPPER_Z);
        is_digit  = (ch_up >= CH_ZERO) && (ch_up <= CH_NINE);
        is_space  = (ch_up == CH_SPACE);
        if (is_letter) begin
            ch_off = ch_up - CH_UPPER_A;
            code   = ch_off[CODE_W-1:0];
        end else begin
            ch_off = ch_up - CH_ZERO;
            code   = ch_off[CODE_W-1:0] + LETTER_COUNT;
        end
        lut = lookup_code(code);
    end

    // Space: word gap less letter gap, clamped at zero.
    assign space_diff = {1'b0, i_cfg.word_gap_ms} - {1'b0, i_cfg.letter_gap_ms};
    assign space_dur  = space_diff[DUR_W] ? '0 : space_diff[DUR_W-1:0];

    always_comb begin
        n_busy   = r_busy;
        n_phase  = r_phase;
        n_pat    = r_pat;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        n_key_on = r_key_on;
        n_dur    = r_dur;
        n_last   = r_last;

        if (o_seg.ready) begin
            n_ovalid = 1'b0;
        end

        if (accept) begin
            if (is_space) begin
                n_busy  = 1'b1;
                n_phase = PH_SPACE;
            end else if (is_letter || is_digit) begin
                n_busy  = 1'b1;
                n_phase = PH_ELEM;
                n_pat   = lut.pat;
                n_cnt   = lut.len;
            end
        end else if (r_busy && slot_free) begin
            n_ovalid = 1'b1;
            unique case (r_phase)
                PH_ELEM: begin
                    n_key_on = 1'b1;
                    n_dur    = r_pat[0] ? i_cfg.dash_ms : i_cfg.dot_ms;
                    n_last   = 1'b0;
                    n_pat    = r_pat >> 1;
                    n_cnt    = r_cnt - 1'b1;
                    n_phase  = (r_cnt == 3'd1) ? PH_LGAP : PH_EGAP;
                end
                PH_EGAP: begin
                    n_key_on = 1'b0;
                    n_dur    = i_cfg.element_gap_ms;
                    n_last   = 1'b0;
                    n_phase  = PH_ELEM;
                end
                PH_LGAP: begin
                    n_key_on = 1'b0;
                    n_dur    = i_cfg.letter_gap_ms;
                    n_last   = 1'b1;
                    n_busy   = 1'b0;
                end
                PH_SPACE: begin
                    n_key_on = 1'b0;
                    n_dur    = space_dur;
                    n_last   = 1'b1;
                    n_busy   = 1'b0;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= PH_ELEM;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat    <= n_pat;
        r_cnt    <= n_cnt;
        r_key_on <= n_key_on;
        r_dur    <= n_dur;
        r_last   <= n_last;
    end

    assign o_seg.valid        = r_ovalid;
    assign o_seg.key_on       = r_key_on;
    assign o_seg.duration_ms  = r_dur;
    assign o_seg.last_segment = r_last;

    // The final segment of a character is always a key-up gap.
    a_last_is_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_last |-> !r_key_on)
        else $error("last segment with key down");

    // An element phase always has at least one element left.
    a_elem_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_phase == PH_ELEM |-> r_cnt != '0)
        else $error("element phase with empty count");

    // A stalled result keeps its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_seg.ready |=> r_ovalid && $stable(r_dur) && $stable(r_last))
        else $error("stalled segment changed");

    // A key-down segment is always followed by more of the same character.
    a_on_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_key_on |-> r_busy)
        else $error("key-down segment without a pending gap");

endmodule

@@ src/morse_code_keyer_encoder_unit.sv @@
// A character is first loaded into the sequencer state; its segments are then registered into
// the output stage one segment per cycle while the output is not stalled. A letter or digit
// gives n segments (2 to 10), a space one segment, and any other byte is taken without a segment.
// A stalled output holds the sequencer, so a stall adds its length to the character's time.
// Reset (synchronous, active low) empties the sequencer and output stage and restores the
// timing registers to 200, 600, 200, 600 and 1400 ms.
module morse_code_keyer_encoder_unit import mcke_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcke_cfg_if.sink    i_cfg,
    mcke_char_if.sink   i_char,
    mcke_seg_if.source  o_seg
);

    // Timing registers. The configuration channel is always ready; a write to
    // an index beyond the word gap register is dropped without effect.
    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot_ms         <= RST_DOT;
            r_cfg.dash_ms        <= RST_DASH;
            r_cfg.element_gap_ms <= RST_ELEMENT_GAP;
            r_cfg.letter_gap_ms  <= RST_LETTER_GAP;
            r_cfg.word_gap_ms    <= RST_WORD_GAP;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DOT:         r_cfg.dot_ms         <= i_cfg.data;
                REG_DASH:        r_cfg.dash_ms        <= i_cfg.data;
                REG_ELEMENT_GAP: r_cfg.element_gap_ms <= i_cfg.data;
                REG_LETTER_GAP:  r_cfg.letter_gap_ms  <= i_cfg.data;
                REG_WORD_GAP:    r_cfg.word_gap_ms    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // The sequencer takes a character word whenever it has finished loading
    // the last segment of the previous one, so the input side is free while
    // that final segment still waits in the output register. Each word is
    // folded to upper case and looked up in the Morse table; its elements
    // then leave a small shift register one per segment, with the element
    // gaps and the closing letter gap inserted between them.
    mcke_segen u_segen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_char  (i_char),
        .o_seg   (o_seg)
    );

endmodule
